>>> sv/hbcu_pkg.sv
// Shared types, constants and helper functions for the heightmap brush cell update.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package hbcu_pkg;

  // Fixed point format and field widths
  localparam int FRAC_BITS = 16;
  localparam int OFS_W     = 28;
  localparam int H_W       = 32;
  localparam int NSUM_W    = 36;
  localparam int RAD_W     = 27;
  localparam int RATE_W    = 25;
  localparam int CFG_W     = 32;

  // Distance: squared offset and its integer root, one root bit per stage
  localparam int D2_W       = 2 * OFS_W;
  localparam int ROOT_STEPS = D2_W / 2;

  // Falloff ratio: quotient bits and dividend width
  localparam int T_W   = FRAC_BITS + 1;
  localparam int NUM_W = RAD_W + FRAC_BITS;

  // Neighbour mean: biased sum divided by nine, two quotient bits per stage
  localparam int U9_W       = 40;
  localparam int DIV9_STEPS = U9_W / 2;
  localparam logic [U9_W-1:0] DIV9_BIAS = U9_W'(9) << (NSUM_W - 1);
  localparam logic [U9_W-1:0] Q9_OFS    = U9_W'(1) << (NSUM_W - 1);

  // Weight and blend arithmetic
  localparam logic [T_W-1:0] ONE       = T_W'(1) << FRAC_BITS;
  localparam logic [T_W:0]   THREE_ONE = (T_W + 1)'(3) << FRAC_BITS;
  localparam int PROD_W = RATE_W + T_W;
  localparam int AMT_W  = PROD_W - FRAC_BITS;
  localparam int DIF_W  = H_W + 1;
  localparam int BL_W   = DIF_W + T_W + 1;
  localparam int SAT_W  = 52;

  // Total latency from accepted item to result strobe
  localparam int FRONT_LAT = 2;
  localparam int BLEND_LAT = 6;
  localparam int PIPE_LAT  = FRONT_LAT + ROOT_STEPS + T_W + BLEND_LAT;

  typedef enum logic [1:0] {
    TOOL_RAISE   = 2'd0,
    TOOL_LOWER   = 2'd1,
    TOOL_FLATTEN = 2'd2,
    TOOL_SMOOTH  = 2'd3
  } tool_t;

  typedef enum logic [1:0] {
    CFG_TOOL_MODE      = 2'd0,
    CFG_BRUSH_RADIUS   = 2'd1,
    CFG_STROKE_RATE    = 2'd2,
    CFG_FLATTEN_TARGET = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    tool_t                    tool_mode;
    logic [RAD_W-1:0]         brush_radius;
    logic [RATE_W-1:0]        stroke_rate;
    logic signed [H_W-1:0]    flatten_target;
  } cfg_t;

  typedef struct packed {
    logic signed [OFS_W-1:0]  offset_x;
    logic signed [OFS_W-1:0]  offset_z;
    logic signed [H_W-1:0]    cell_height;
    logic signed [NSUM_W-1:0] neighbour_sum;
  } in_t;

  typedef struct packed {
    logic signed [H_W-1:0]    new_height;
    logic                     inside_brush;
  } out_t;

  // Front end to root pipeline
  typedef struct packed {
    logic                     valid;
    logic                     in_brush;
    logic signed [H_W-1:0]    height;
    logic [D2_W-1:0]          d2;
    logic [U9_W-1:0]          u9;
  } front_t;

  // One stage of the root pipeline
  typedef struct packed {
    logic                     valid;
    logic                     in_brush;
    logic signed [H_W-1:0]    height;
    logic [D2_W-1:0]          rem;
    logic [D2_W-1:0]          root;
    logic [U9_W-1:0]          u9;
    logic [U9_W-1:0]          q9;
    logic [3:0]               r9;
  } root_stg_t;

  // Root pipeline to divider
  typedef struct packed {
    logic                     valid;
    logic                     in_brush;
    logic signed [H_W-1:0]    height;
    logic [ROOT_STEPS-1:0]    radial;
    logic [U9_W-1:0]          q9;
  } root_out_t;

  // One stage of the divider
  typedef struct packed {
    logic                     valid;
    logic                     in_brush;
    logic signed [H_W-1:0]    height;
    logic [U9_W-1:0]          q9;
    logic [NUM_W-1:0]         rem;
    logic [T_W-1:0]           quo;
  } div_stg_t;

  // Divider to blend stages
  typedef struct packed {
    logic                     valid;
    logic                     in_brush;
    logic signed [H_W-1:0]    height;
    logic [U9_W-1:0]          q9;
    logic [T_W-1:0]           t;
  } div_out_t;

  typedef struct packed {
    logic                     in_brush;
    logic signed [H_W-1:0]    height;
  } side_t;

  // One long-division step by nine: returns {quotient bit, remainder}
  function automatic logic [4:0] div9_step(input logic [3:0] rem, input logic b);
    logic [4:0] trial;
    trial = {rem, b};
    if (trial >= 5'd9) begin
      return {1'b1, 4'(trial - 5'd9)};
    end
    return {1'b0, trial[3:0]};
  endfunction

  // Clamp a wide signed value to the height range
  function automatic logic signed [H_W-1:0] sat_h(input logic signed [SAT_W-1:0] x);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'({1'b0, {(H_W-1){1'b1}}});
    lo = -hi - SAT_W'(1);
    if (x > hi) begin
      return {1'b0, {(H_W-1){1'b1}}};
    end
    if (x < lo) begin
      return {1'b1, {(H_W-1){1'b0}}};
    end
    return H_W'(x);
  endfunction

endpackage

>>> sv/hbcu_cfg.sv
// Configuration register file: tool mode, brush radius, stroke rate, flatten target.
// Depends on hbcu_pkg.
`timescale 1ns / 1ps

module hbcu_cfg
  import hbcu_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output logic             cfg_ready,
  output cfg_t             cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Always ready: a write lands in the register at the edge that accepts it
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Decode the write transaction
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TOOL_MODE:      cfg_nxt.tool_mode      = tool_t'(cfg_data[1:0]);
        CFG_BRUSH_RADIUS:   cfg_nxt.brush_radius   = cfg_data[RAD_W-1:0];
        CFG_STROKE_RATE:    cfg_nxt.stroke_rate    = cfg_data[RATE_W-1:0];
        CFG_FLATTEN_TARGET: cfg_nxt.flatten_target = $signed(cfg_data[H_W-1:0]);
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  // Hold the registers, load reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tool_mode      <= TOOL_RAISE;
      cfg_r.brush_radius   <= RAD_W'(327680);
      cfg_r.stroke_rate    <= RATE_W'(65536);
      cfg_r.flatten_target <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> sv/hbcu_front.sv
// Front end: squares the offsets, forms the squared distance and the inside test,
// and biases the neighbour sum for the divide by nine. Depends on hbcu_pkg.
`timescale 1ns / 1ps

module hbcu_front
  import hbcu_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_vld,
  input  in_t    in_data,
  input  cfg_t   cfg,
  output front_t front
);

  logic                     v1_r;
  logic [D2_W-1:0]          sqx_r;
  logic [D2_W-1:0]          sqz_r;
  logic [2*RAD_W-1:0]       rr_r;
  logic signed [H_W-1:0]    h1_r;
  logic [U9_W-1:0]          u1_r;

  logic signed [D2_W-1:0]   ox;
  logic signed [D2_W-1:0]   oz;
  logic [D2_W-1:0]          sqx_nxt;
  logic [D2_W-1:0]          sqz_nxt;
  logic [2*RAD_W-1:0]       rr_nxt;
  logic [D2_W-1:0]          d2;

  front_t front_r;
  front_t front_nxt;

  // Stage 1: three squares
  always_comb begin
    ox      = D2_W'(in_data.offset_x);
    oz      = D2_W'(in_data.offset_z);
    sqx_nxt = ox * ox;
    sqz_nxt = oz * oz;
    rr_nxt  = cfg.brush_radius * cfg.brush_radius;
  end

  always_ff @(posedge clk) begin
    sqx_r <= sqx_nxt;
    sqz_r <= sqz_nxt;
    rr_r  <= rr_nxt;
    h1_r  <= in_data.cell_height;
    u1_r  <= U9_W'(in_data.neighbour_sum) + DIV9_BIAS;
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
    end
  end

  // Stage 2: sum and strict compare against the squared radius
  always_comb begin
    d2                 = sqx_r + sqz_r;
    front_nxt.valid    = v1_r;
    front_nxt.in_brush = d2 < D2_W'(rr_r);
    front_nxt.height   = h1_r;
    front_nxt.d2       = d2;
    front_nxt.u9       = u1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
    end else begin
      front_r <= front_nxt;
    end
  end

  assign front = front_r;

endmodule

>>> sv/hbcu_sqrt.sv
// Integer square root pipeline, one root bit per stage; carries the biased
// neighbour sum through a divide by nine in its first stages. Depends on hbcu_pkg.
`timescale 1ns / 1ps

module hbcu_sqrt
  import hbcu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  front_t    front,
  output root_out_t root_out
);

  root_stg_t stg_in;
  root_stg_t stg_r [1:ROOT_STEPS];

  // Load the first stage from the front end
  always_comb begin
    stg_in          = '0;
    stg_in.valid    = front.valid;
    stg_in.in_brush = front.in_brush;
    stg_in.height   = front.height;
    stg_in.rem      = front.d2;
    stg_in.u9       = front.u9;
  end

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
    localparam logic [D2_W-1:0] BIT = D2_W'(1) << (2 * (ROOT_STEPS - 1 - k));
    root_stg_t      cur;
    root_stg_t      stp_nxt;
    logic [D2_W:0]  trial;
    logic [4:0]     d9a;
    logic [4:0]     d9b;

    if (k == 0) begin : g_first
      assign cur = stg_in;
    end else begin : g_rest
      assign cur = stg_r[k];
    end

    // Try the next root bit; advance the divide by nine two bits
    always_comb begin
      stp_nxt = cur;
      trial   = {1'b0, cur.root} + {1'b0, BIT};
      d9a     = div9_step(cur.r9, cur.u9[U9_W-1]);
      d9b     = div9_step(d9a[3:0], cur.u9[U9_W-2]);
      if ({1'b0, cur.rem} >= trial) begin
        stp_nxt.rem  = cur.rem - trial[D2_W-1:0];
        stp_nxt.root = (cur.root >> 1) + BIT;
      end else begin
        stp_nxt.root = cur.root >> 1;
      end
      if (k < DIV9_STEPS) begin
        stp_nxt.u9 = cur.u9 << 2;
        stp_nxt.q9 = {cur.q9[U9_W-3:0], d9a[4], d9b[4]};
        stp_nxt.r9 = d9b[3:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_r[k+1] <= '0;
      end else begin
        stg_r[k+1] <= stp_nxt;
      end
    end
  end

  assign root_out.valid    = stg_r[ROOT_STEPS].valid;
  assign root_out.in_brush = stg_r[ROOT_STEPS].in_brush;
  assign root_out.height   = stg_r[ROOT_STEPS].height;
  assign root_out.radial   = stg_r[ROOT_STEPS].root[ROOT_STEPS-1:0];
  assign root_out.q9       = stg_r[ROOT_STEPS].q9;

endmodule

>>> sv/hbcu_div.sv
// Restoring divider for the falloff ratio t = ((radius - dist) << FRAC_BITS) / radius,
// one quotient bit per stage. Depends on hbcu_pkg.
`timescale 1ns / 1ps

module hbcu_div
  import hbcu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  root_out_t root_out,
  input  cfg_t      cfg,
  output div_out_t  div_out
);

  div_stg_t stg_in;
  div_stg_t stg_r [1:T_W];

  // Form the dividend; the distance is below the radius for an inside cell
  always_comb begin
    stg_in          = '0;
    stg_in.valid    = root_out.valid;
    stg_in.in_brush = root_out.in_brush;
    stg_in.height   = root_out.height;
    stg_in.q9       = root_out.q9;
    stg_in.rem      = NUM_W'(RAD_W'(cfg.brush_radius - root_out.radial[RAD_W-1:0]))
                      << FRAC_BITS;
  end

  for (genvar j = 0; j < T_W; j++) begin : g_step
    div_stg_t         cur;
    div_stg_t         stp_nxt;
    logic [NUM_W-1:0] dvs;

    if (j == 0) begin : g_first
      assign cur = stg_in;
    end else begin : g_rest
      assign cur = stg_r[j];
    end

    // Subtract the shifted radius where it fits
    always_comb begin
      stp_nxt = cur;
      dvs     = NUM_W'(cfg.brush_radius) << (FRAC_BITS - j);
      if (cur.rem >= dvs) begin
        stp_nxt.rem = cur.rem - dvs;
        stp_nxt.quo = {cur.quo[T_W-2:0], 1'b1};
      end else begin
        stp_nxt.quo = {cur.quo[T_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_r[j+1] <= '0;
      end else begin
        stg_r[j+1] <= stp_nxt;
      end
    end
  end

  assign div_out.valid    = stg_r[T_W].valid;
  assign div_out.in_brush = stg_r[T_W].in_brush;
  assign div_out.height   = stg_r[T_W].height;
  assign div_out.q9       = stg_r[T_W].q9;
  assign div_out.t        = stg_r[T_W].quo;

endmodule

>>> sv/hbcu_blend.sv
// Back end: smoothstep weight, stroke amount and blend factor, then the tool update
// with saturation, over six register stages. Depends on hbcu_pkg.
`timescale 1ns / 1ps

module hbcu_blend
  import hbcu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_out_t div_out,
  input  cfg_t     cfg,
  output logic     out_valid,
  output out_t     out_data
);

  logic [BLEND_LAT-1:0] v_r;
  side_t                s1_r, s2_r, s3_r, s4_r, s5_r;
  logic [U9_W-1:0]      q1_r, q2_r, q3_r;

  logic [2*T_W-1:0]       tt;
  logic [T_W-1:0]         t2_r;
  logic [T_W:0]           m_r;
  logic [2*T_W:0]         wp;
  logic [T_W-1:0]         w_r;
  logic [PROD_W-1:0]      prod_nxt;
  logic [PROD_W-1:0]      prod_r;
  logic [PROD_W-1:0]      fsh;
  logic [T_W-1:0]         f_nxt;
  logic [T_W-1:0]         f_r;
  logic [AMT_W-1:0]       amt_r;
  logic signed [U9_W:0]   q9s;
  logic signed [H_W-1:0]  goal;
  logic signed [DIF_W-1:0] diff_r;
  logic signed [SAT_W-1:0] up;
  logic signed [SAT_W-1:0] dn;
  logic signed [H_W-1:0]  rl_r;
  logic signed [BL_W-1:0] bl_nxt;
  logic signed [BL_W-1:0] bl_r;
  logic signed [H_W-1:0]  blended;
  out_t                   out_nxt;
  out_t                   out_r;

  // Stage 1: t squared and 3 - 2t
  always_comb tt = div_out.t * div_out.t;

  always_ff @(posedge clk) begin
    t2_r <= tt[FRAC_BITS +: T_W];
    m_r  <= THREE_ONE - {div_out.t, 1'b0};
    s1_r <= '{in_brush: div_out.in_brush, height: div_out.height};
    q1_r <= div_out.q9;
  end

  // Stage 2: smoothstep weight
  always_comb wp = t2_r * m_r;

  always_ff @(posedge clk) begin
    w_r  <= wp[FRAC_BITS +: T_W];
    s2_r <= s1_r;
    q2_r <= q1_r;
  end

  // Stage 3: stroke rate times weight
  always_comb prod_nxt = cfg.stroke_rate * w_r;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    s3_r   <= s2_r;
    q3_r   <= q2_r;
  end

  // Stage 4: amount, capped blend factor, distance to the goal
  always_comb begin
    fsh = prod_r >> (FRAC_BITS + 2);
    if (fsh > PROD_W'(ONE)) begin
      f_nxt = ONE;
    end else begin
      f_nxt = T_W'(fsh);
    end
    q9s = $signed({1'b0, q3_r}) - $signed({1'b0, Q9_OFS});
    if (cfg.tool_mode == TOOL_FLATTEN) begin
      goal = cfg.flatten_target;
    end else begin
      goal = sat_h(SAT_W'(q9s));
    end
  end

  always_ff @(posedge clk) begin
    amt_r  <= prod_r[PROD_W-1:FRAC_BITS];
    f_r    <= f_nxt;
    diff_r <= DIF_W'(goal) - DIF_W'(s3_r.height);
    s4_r   <= s3_r;
  end

  // Stage 5: blend product and saturated raise or lower
  always_comb begin
    bl_nxt = diff_r * $signed({1'b0, f_r});
    up     = SAT_W'(s4_r.height) + SAT_W'($signed({1'b0, amt_r}));
    dn     = SAT_W'(s4_r.height) - SAT_W'($signed({1'b0, amt_r}));
  end

  always_ff @(posedge clk) begin
    bl_r <= bl_nxt;
    rl_r <= (cfg.tool_mode == TOOL_LOWER) ? sat_h(dn) : sat_h(up);
    s5_r <= s4_r;
  end

  // Stage 6: pick the tool result, pass outside cells through
  always_comb begin
    blended = sat_h(SAT_W'(s5_r.height) + SAT_W'(bl_r >>> FRAC_BITS));
    out_nxt.inside_brush = s5_r.in_brush;
    out_nxt.new_height   = s5_r.height;
    if (s5_r.in_brush) begin
      case (cfg.tool_mode) inside
        TOOL_RAISE, TOOL_LOWER: out_nxt.new_height = rl_r;
        default:                out_nxt.new_height = blended;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // Valid bits travel with the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[BLEND_LAT-2:0], div_out.valid};
    end
  end

  assign out_valid = v_r[BLEND_LAT-1];
  assign out_data  = out_r;

endmodule

>>> sv/heightmap_brush_cell_update_top.sv
// Heightmap brush cell update: one cell under a circular sculpt brush per transaction.
// Top level; depends on hbcu_pkg, hbcu_cfg, hbcu_front, hbcu_sqrt, hbcu_div, hbcu_blend.
//
// Usage:
//   Input: drive in_data and raise start; the transaction is taken at a clock edge
//   with start high and busy low. busy stays low, so one cell enters every cycle.
//   Output: each cell gives one result, shown on out_data for exactly one cycle with
//   out_valid high; the receiver takes it in that cycle and cannot hold it off.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high and a write is registered when accepted. Write only with the pipeline empty.
//   Pipeline: from accept to out_valid, the squares and the inside test, then 28 root
//   stages (one bit of the 28-bit distance each), 17 divider stages (one bit of the
//   falloff ratio each) and 6 weight and blend stages.
//   Throughput: one cell per cycle, held by the fully pipelined root and divider.
//   Reset (rst_n low, synchronous): all valid bits clear, so no stale result
//   appears, and the registers return to raise, radius 5.0, rate 1.0, target 0.
//   Results are never stalled; a cell issued every cycle leaves every cycle.
`timescale 1ns / 1ps

module heightmap_brush_cell_update_top
  import hbcu_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_t              in_data,
  output logic             out_valid,
  output out_t             out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  cfg_t      cfg;
  front_t    front;
  root_out_t root_out;
  div_out_t  div_out;
  logic      in_vld;

  // Never stall the input
  assign busy   = 1'b0;
  assign in_vld = start && !busy;

  hbcu_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .cfg       (cfg)
  );

  hbcu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_vld),
    .in_data (in_data),
    .cfg     (cfg),
    .front   (front)
  );

  hbcu_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .front    (front),
    .root_out (root_out)
  );

  hbcu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .root_out (root_out),
    .cfg      (cfg),
    .div_out  (div_out)
  );

  hbcu_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .div_out   (div_out),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTH
  // Every result comes from a transaction exactly one pipeline latency earlier
  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LAT))
    else $error("result without a matching input transaction");

  // A cell outside the brush leaves with its height untouched
  a_outside_passes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.inside_brush) |->
      (out_data.new_height == $past(in_data.cell_height, PIPE_LAT)))
    else $error("outside cell height changed");
`endif

endmodule

>>> dv/heightmap_brush_cell_update_top_test.sv
// Self-checking test of the heightmap brush cell update against a bit-exact cell predictor.
// Depends on hbcu_pkg and heightmap_brush_cell_update_top.
`timescale 1ns / 1ps

module heightmap_brush_cell_update_top_test;
  import hbcu_pkg::*;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  in_t              in_data = '0;
  logic             out_valid;
  out_t             out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  heightmap_brush_cell_update_top u_top (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #2 clk = ~clk;

  // Predictor copy of the brush registers
  tool_t                 brush_tool;
  logic [RAD_W-1:0]      brush_rad;
  logic [RATE_W-1:0]     brush_rate;
  logic signed [H_W-1:0] brush_target;

  in_t   pending_cells[$];
  out_t  expected_heights[$];
  int    error_count = 0;
  longint cycle_count = 0;
  int    cfg_pending = 0;
  logic [1:0]       cfg_idx_q[$];
  logic [CFG_W-1:0] cfg_val_q[$];

  function automatic longint floor_asr(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint clamp_h(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Compute the updated cell for the current brush settings
  function automatic out_t brush_cell(in_t c);
    out_t o;
    longint dx, dz, hgt, nsum, res, f, amount, goal, q;
    longint unsigned d2, r, droot, t, t2, w, prod, one;
    one = 64'd1 << FRAC_BITS;
    dx = c.offset_x;
    dz = c.offset_z;
    hgt = c.cell_height;
    nsum = c.neighbour_sum;
    d2 = dx * dx + dz * dz;
    r = brush_rad;
    res = hgt;
    o.inside_brush = 1'b0;
    if (d2 < r * r) begin
      droot = int_root(d2);
      t = ((r - droot) << FRAC_BITS) / r;
      t2 = (t * t) >> FRAC_BITS;
      w = (t2 * (3 * one - 2 * t)) >> FRAC_BITS;
      prod = brush_rate * w;
      amount = prod >> FRAC_BITS;
      f = prod >> (FRAC_BITS + 2);
      if (f > one) f = one;
      o.inside_brush = 1'b1;
      case (brush_tool)
        TOOL_RAISE: res = clamp_h(hgt + amount);
        TOOL_LOWER: res = clamp_h(hgt - amount);
        TOOL_FLATTEN: res = clamp_h(hgt + floor_asr((longint'(brush_target) - hgt) * f,
                                                    FRAC_BITS));
        default: begin
          q = nsum / 9;
          if (nsum % 9 < 0) q -= 1;
          goal = clamp_h(q);
          res = clamp_h(hgt + floor_asr((goal - hgt) * f, FRAC_BITS));
        end
      endcase
    end
    o.new_height = res[H_W-1:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // Driver: present queued register writes, then queued cells with random gaps
  int gap_left = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      // Retire the accepted register write before presenting the next one
      if (cfg_valid && cfg_ready) begin
        void'(cfg_idx_q.pop_front());
        void'(cfg_val_q.pop_front());
        cfg_pending <= cfg_pending - 1;
      end
      if (cfg_idx_q.size() > 0 && !start) begin
        cfg_valid <= 1'b1;
        cfg_index <= cfg_idx_q[0];
        cfg_data  <= cfg_val_q[0];
      end else begin
        cfg_valid <= 1'b0;
      end
      if (start && !busy) begin
        expected_heights.push_back(brush_cell(in_data));
        void'(pending_cells.pop_front());
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_cells.size() > 0 && cfg_idx_q.size() == 0) begin
        start   <= 1'b1;
        in_data <= pending_cells[0];
        if ($urandom_range(0, 3) == 0)
          gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                  : $urandom_range(1, 3);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_heights.size() == 0) begin
        report_mismatch("unexpected result", out_data.new_height, 0);
      end else begin
        if (out_data.new_height !== expected_heights[0].new_height)
          report_mismatch("new_height", out_data.new_height, expected_heights[0].new_height);
        if (out_data.inside_brush !== expected_heights[0].inside_brush)
          report_mismatch("inside_brush", out_data.inside_brush,
                          expected_heights[0].inside_brush);
        expected_heights.pop_front();
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [27:0] rand_ofs(int span);
    case ($urandom_range(0, 5))
      0: return 28'($urandom);
      1: return 28'h8000000;
      2: return 28'h7ffffff;
      default: return 28'($signed($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  function automatic in_t rand_cell(int span);
    in_t c;
    c.offset_x = rand_ofs(span);
    c.offset_z = rand_ofs(span);
    c.cell_height = ($urandom_range(0, 3) == 0) ? $urandom
                    : 32'($signed($urandom_range(0, 2000000)) - 1000000);
    c.neighbour_sum = 36'({$urandom, $urandom});
    return c;
  endfunction

  task automatic wait_drained();
    while (pending_cells.size() > 0 || start || expected_heights.size() > 0)
      @(posedge clk);
    repeat (PIPE_LAT + 5) @(posedge clk);
  endtask

  // Apply one register write and mirror it in the predictor
  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    cfg_idx_q.push_back(idx);
    cfg_val_q.push_back(val);
    cfg_pending++;
    case (idx)
      CFG_TOOL_MODE:      brush_tool = tool_t'(val[1:0]);
      CFG_BRUSH_RADIUS:   brush_rad = val[RAD_W-1:0];
      CFG_STROKE_RATE:    brush_rate = val[RATE_W-1:0];
      CFG_FLATTEN_TARGET: brush_target = val;
    endcase
    while (cfg_pending > 0) @(posedge clk);
  endtask

  initial begin
    in_t c;
    int span;
    brush_tool = TOOL_RAISE;
    brush_rad = 27'd327680;
    brush_rate = 25'd65536;
    brush_target = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: centre, edges, extremes at reset settings
    c = '0; c.cell_height = 32'h7fffffff; pending_cells.push_back(c);
    c.offset_x = 28'sd327680; pending_cells.push_back(c);
    c.offset_x = 28'sd327679; c.cell_height = 32'h80000000; pending_cells.push_back(c);
    c.offset_x = 28'h8000000; c.offset_z = 28'h8000000; pending_cells.push_back(c);
    c.offset_x = 28'h7ffffff; c.offset_z = 28'h7ffffff; pending_cells.push_back(c);
    wait_drained();
    for (int m = 0; m < 4; m++) begin
      write_reg(CFG_TOOL_MODE, m);
      write_reg(CFG_STROKE_RATE, (m == 3) ? 32'd16777216 : 32'd33554431);
      write_reg(CFG_FLATTEN_TARGET, (m == 2) ? 32'h80000000 : 32'h7fffffff);
      c = '0; c.cell_height = 32'h80000000; c.neighbour_sum = 36'h800000000;
      pending_cells.push_back(c);
      c.cell_height = 32'h7fffffff; c.neighbour_sum = 36'h7ffffffff;
      pending_cells.push_back(c);
      c.offset_z = 28'sd1000; c.neighbour_sum = 36'h0; pending_cells.push_back(c);
      wait_drained();
    end
    write_reg(CFG_STROKE_RATE, 0);
    c = '0; c.cell_height = 32'sd12345; pending_cells.push_back(c);
    write_reg(CFG_BRUSH_RADIUS, 1);
    pending_cells.push_back(c);
    c.offset_x = 28'sd1; pending_cells.push_back(c);
    wait_drained();
    write_reg(CFG_BRUSH_RADIUS, 0);
    c = '0; pending_cells.push_back(c);
    wait_drained();

    // Random phases over many settings
    for (int p = 0; p < 16; p++) begin
      write_reg(CFG_TOOL_MODE, $urandom_range(0, 3));
      case (p % 4)
        0: write_reg(CFG_BRUSH_RADIUS, 32'h7ffffff);
        1: write_reg(CFG_BRUSH_RADIUS, $urandom_range(1, 20));
        default: write_reg(CFG_BRUSH_RADIUS, $urandom_range(1, 134217727));
      endcase
      write_reg(CFG_STROKE_RATE, (p % 5 == 0) ? 16777216 : $urandom_range(0, 16777216));
      write_reg(CFG_FLATTEN_TARGET, $urandom);
      span = (brush_rad > 2) ? int'(brush_rad) : 4;
      for (int k = 0; k < 50; k++) pending_cells.push_back(rand_cell(span));
      wait_drained();
    end

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
